>>> src/rmb_pkg.sv
// Shared constants, types and helpers for the recursive mutex bank.
// No dependencies; imported by recursive_mutex_bank.
`timescale 1ns / 1ps

package rmb_pkg;

  localparam int MUTEX_COUNT  = 16;
  localparam int THREAD_COUNT = 16;
  localparam int COUNT_BITS   = 8;
  localparam int MAX_RESULTS  = 16;

  localparam int MIDX_W = $clog2(MUTEX_COUNT);
  localparam int TIDX_W = $clog2(THREAD_COUNT);
  localparam int LINK_W = MIDX_W + 1;
  localparam int K_W    = $clog2(MAX_RESULTS);

  typedef logic [LINK_W-1:0] link_t;
  localparam link_t NIL = '1;
  localparam logic [K_W-1:0] K_LAST = K_W'(MAX_RESULTS - 1);

  typedef enum logic [1:0] {
    OP_LOCK       = 2'd0,
    OP_TRY        = 2'd1,
    OP_UNLOCK     = 2'd2,
    OP_UNLOCK_ALL = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_GRANTED   = 3'd0,
    ST_WAIT      = 3'd1,
    ST_BUSY      = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DECR      = 3'd4,
    ST_RELEASED  = 3'd5,
    ST_NOT_OWNER = 3'd6,
    ST_NONE      = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_WALK,
    S_FIX_NW,
    S_FIX_OD
  } state_e;

  typedef struct packed {
    op_e        operation;
    logic [3:0] mutex_index;
    logic [3:0] thread_id;
  } req_t;

  typedef struct packed {
    status_e     status;
    logic [3:0]  result_mutex;
    logic [15:0] woken_threads;
    logic        last_result;
  } rsp_t;

  typedef struct packed {
    logic                    valid;
    logic [TIDX_W-1:0]       owner;
    logic [COUNT_BITS-1:0]   count;
    logic [THREAD_COUNT-1:0] waiters;
    link_t                   newer;
    link_t                   older;
  } mutex_ent_t;

  typedef struct packed {
    link_t newest;
    link_t oldest;
  } thread_ent_t;

  localparam mutex_ent_t MENT_RESET = '{
    valid:   1'b0,
    owner:   '0,
    count:   '0,
    waiters: '0,
    newer:   NIL,
    older:   NIL
  };

  localparam thread_ent_t TENT_RESET = '{newest: NIL, oldest: NIL};

  function automatic logic link_ok(input link_t l);
    return 32'(l) < MUTEX_COUNT;
  endfunction

endpackage

>>> src/recursive_mutex_bank.sv
// Recursive mutex bank: per-mutex table and per-thread held-list table in
// synchronous memories, driven by a read-modify-write sequencer. Uses rmb_pkg.
`timescale 1ns / 1ps

// Lock, try-lock and unlock answer from the evaluate state; unlock-all answers
// from each walk state, or from evaluate when nothing is held. Relinking a list
// neighbor adds a fix state each (at most 2). Unlock-all walks once per released
// mutex, plus a fix state when held mutexes remain; one mutex-table port pair.
// Reset: per-entry written flags clear at once; unwritten entries read as free.
// Results are strobed for one cycle; the receiver cannot stall.
module recursive_mutex_bank (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  rmb_pkg::req_t req_i,
  output logic          busy,
  output logic          result_valid_o,
  output rmb_pkg::rsp_t result_o
);
  import rmb_pkg::*;

  state_e state_q, state_d;

  op_e        op_q;
  logic [3:0] m_q;
  logic [3:0] t_q;
  link_t      nw_q, nw_d;
  link_t      od_q, od_d;
  link_t      o_q, o_d;
  logic [K_W-1:0] k_q, k_d;
  thread_ent_t th_q, th_d;

  mutex_ent_t  mutex_mem [MUTEX_COUNT];
  thread_ent_t thread_mem [THREAD_COUNT];
  logic [MUTEX_COUNT-1:0]  m_wr_q;
  logic [THREAD_COUNT-1:0] t_wr_q;
  mutex_ent_t  m_rdata_q;
  thread_ent_t t_rdata_q;
  logic        m_rvld_q, t_rvld_q;

  logic              m_we, t_we;
  logic [MIDX_W-1:0] m_waddr, m_raddr;
  logic [TIDX_W-1:0] t_raddr;
  mutex_ent_t        m_wdata;
  thread_ent_t       t_wdata;

  logic res_vld_d;
  rsp_t res_d;

  mutex_ent_t  me;
  thread_ent_t th;
  logic        accept;
  logic        m_ok, t_ok, owned;
  logic        me_nw_ok, me_od_ok, head_ok, oldest_ok;
  logic        is_push, is_release, eval_walk, walk_last;
  link_t       m_lnk;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign me        = m_rvld_q ? m_rdata_q : MENT_RESET;
  assign th        = t_rvld_q ? t_rdata_q : TENT_RESET;
  assign m_ok      = 32'(m_q) < MUTEX_COUNT;
  assign t_ok      = 32'(t_q) < THREAD_COUNT;
  assign m_lnk     = LINK_W'(m_q);
  assign owned     = me.valid && (me.owner == TIDX_W'(t_q));
  assign me_nw_ok  = link_ok(me.newer);
  assign me_od_ok  = link_ok(me.older);
  assign head_ok   = link_ok(th.newest);
  assign oldest_ok = link_ok(th.oldest);
  assign is_push   = ((op_q == OP_LOCK) || (op_q == OP_TRY)) && m_ok && t_ok && !me.valid;
  assign is_release = (op_q == OP_UNLOCK) && m_ok && t_ok && owned
                      && !(me.count > COUNT_BITS'(1));
  assign eval_walk = (op_q == OP_UNLOCK_ALL) && t_ok && oldest_ok;
  assign walk_last = !me_nw_ok || (k_q == K_LAST);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_EVAL;
      end
      S_EVAL: begin
        if (is_push && head_ok) state_d = S_FIX_OD;
        else if (is_release && me_nw_ok) state_d = S_FIX_NW;
        else if (is_release && me_od_ok) state_d = S_FIX_OD;
        else if (eval_walk) state_d = S_WALK;
        else state_d = S_IDLE;
      end
      S_WALK: begin
        if (!walk_last) state_d = S_WALK;
        else if (me_nw_ok) state_d = S_FIX_NW;
        else state_d = S_IDLE;
      end
      S_FIX_NW: begin
        state_d = link_ok(od_q) ? S_FIX_OD : S_IDLE;
      end
      S_FIX_OD: state_d = S_IDLE;
      default:  state_d = S_IDLE;
    endcase
  end

  always_comb begin
    m_we    = 1'b0;
    m_waddr = MIDX_W'(m_q);
    m_wdata = me;
    m_raddr = MIDX_W'(m_q);
    t_we    = 1'b0;
    t_wdata = th;
    t_raddr = TIDX_W'(t_q);
    nw_d    = nw_q;
    od_d    = od_q;
    o_d     = o_q;
    k_d     = k_q;
    th_d    = th_q;
    res_vld_d = 1'b0;
    res_d = '{status: ST_GRANTED, result_mutex: m_q, woken_threads: '0, last_result: 1'b1};

    unique case (state_q)
      S_IDLE: begin
        m_raddr = MIDX_W'(req_i.mutex_index);
        t_raddr = TIDX_W'(req_i.thread_id);
      end
      S_EVAL: begin
        case (op_q) inside
          OP_LOCK, OP_TRY: begin
            res_vld_d = 1'b1;
            if (!(m_ok && t_ok)) begin
              res_d.status = ST_BUSY;
            end else if (!me.valid) begin
              m_we    = 1'b1;
              m_wdata = '{valid: 1'b1, owner: TIDX_W'(t_q), count: COUNT_BITS'(1),
                          waiters: me.waiters, newer: NIL, older: th.newest};
              t_we    = 1'b1;
              t_wdata = '{newest: m_lnk, oldest: head_ok ? th.oldest : m_lnk};
              res_d.status = ST_GRANTED;
              m_raddr = MIDX_W'(th.newest);
              od_d    = th.newest;
              nw_d    = m_lnk;
            end else if (owned) begin
              if (me.count == '1) begin
                res_d.status = ST_OVERFLOW;
              end else begin
                m_we          = 1'b1;
                m_wdata.count = me.count + COUNT_BITS'(1);
                res_d.status  = ST_GRANTED;
              end
            end else if (op_q == OP_TRY) begin
              res_d.status = ST_BUSY;
            end else begin
              m_we            = 1'b1;
              m_wdata.waiters = me.waiters | (THREAD_COUNT'(1) << TIDX_W'(t_q));
              res_d.status    = ST_WAIT;
            end
          end
          OP_UNLOCK: begin
            res_vld_d = 1'b1;
            if (!(m_ok && t_ok && owned)) begin
              res_d.status = ST_NOT_OWNER;
            end else if (me.count > COUNT_BITS'(1)) begin
              m_we          = 1'b1;
              m_wdata.count = me.count - COUNT_BITS'(1);
              res_d.status  = ST_DECR;
            end else begin
              m_we    = 1'b1;
              m_wdata = MENT_RESET;
              t_we    = 1'b1;
              t_wdata = '{newest: me_nw_ok ? th.newest : me.older,
                          oldest: me_od_ok ? th.oldest : me.newer};
              res_d.status        = ST_RELEASED;
              res_d.woken_threads = 16'(me.waiters);
              nw_d    = me.newer;
              od_d    = me.older;
              m_raddr = me_nw_ok ? MIDX_W'(me.newer) : MIDX_W'(me.older);
            end
          end
          default: begin
            if (eval_walk) begin
              o_d     = th.oldest;
              k_d     = '0;
              th_d    = th;
              m_raddr = MIDX_W'(th.oldest);
            end else begin
              res_vld_d          = 1'b1;
              res_d.status       = ST_NONE;
              res_d.result_mutex = '0;
            end
          end
        endcase
      end
      S_WALK: begin
        m_we    = 1'b1;
        m_waddr = MIDX_W'(o_q);
        m_wdata = MENT_RESET;
        t_we    = 1'b1;
        t_wdata = '{newest: me_nw_ok ? th_q.newest : NIL, oldest: me.newer};
        th_d    = t_wdata;
        res_vld_d           = 1'b1;
        res_d.status        = ST_RELEASED;
        res_d.result_mutex  = 4'(o_q);
        res_d.woken_threads = 16'(me.waiters);
        res_d.last_result   = walk_last;
        m_raddr = MIDX_W'(me.newer);
        if (!walk_last) begin
          o_d = me.newer;
          k_d = k_q + K_W'(1);
        end else begin
          nw_d = me.newer;
          od_d = NIL;
        end
      end
      S_FIX_NW: begin
        m_we          = 1'b1;
        m_waddr       = MIDX_W'(nw_q);
        m_wdata.older = od_q;
        m_raddr       = MIDX_W'(od_q);
      end
      S_FIX_OD: begin
        m_we          = 1'b1;
        m_waddr       = MIDX_W'(od_q);
        m_wdata.newer = nw_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (m_we) mutex_mem[m_waddr] <= m_wdata;
    if (t_we) thread_mem[TIDX_W'(t_q)] <= t_wdata;
    m_rdata_q <= mutex_mem[m_raddr];
    t_rdata_q <= thread_mem[t_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_wr_q   <= '0;
      t_wr_q   <= '0;
      m_rvld_q <= 1'b0;
      t_rvld_q <= 1'b0;
    end else begin
      if (m_we) m_wr_q[m_waddr] <= 1'b1;
      if (t_we) t_wr_q[TIDX_W'(t_q)] <= 1'b1;
      m_rvld_q <= m_wr_q[m_raddr];
      t_rvld_q <= t_wr_q[t_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      result_valid_o <= 1'b0;
    end else begin
      state_q        <= state_d;
      result_valid_o <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q <= req_i.operation;
      m_q  <= req_i.mutex_index;
      t_q  <= req_i.thread_id;
    end
    nw_q     <= nw_d;
    od_q     <= od_d;
    o_q      <= o_d;
    k_q      <= k_d;
    th_q     <= th_d;
    result_o <= res_d;
  end

endmodule
